/* sv/crcbs_pkg.sv */
// ============================================================================
// crcbs_pkg : shared types and function of the crc bloom signature block
// beat structures, crc-32 constants and the byte-wide crc update
// ============================================================================
package crcbs_pkg;

    localparam int unsigned MAX_LEN    = 512;
    localparam int unsigned COUNT_W    = 10;
    localparam int unsigned CHUNK_BITS = 6;
    localparam int unsigned NUM_CHUNKS = 6;
    localparam int unsigned SIG_W      = 1 << CHUNK_BITS;
    localparam int unsigned WEIGHT_W   = 7;

    localparam logic [31:0]        CRC_POLY  = 32'hEDB8_8320;
    localparam logic [31:0]        CRC_INIT  = 32'hFFFF_FFFF;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [COUNT_W-1:0] LEN_LIMIT = COUNT_W'(MAX_LEN);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } in_beat_t;

    typedef struct packed {
        logic [SIG_W-1:0]    signature;
        logic [WEIGHT_W-1:0] weight;
        logic                contained;
        logic                too_long;
    } out_beat_t;

    // one byte folded into a reflected crc, one bit per step
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

/* sv/crcbs_sig.sv */
// ============================================================================
// crcbs_sig : bloom signature of a finished crc
// signature bits, weight and filter containment in one combinational pass
// ============================================================================
module crcbs_sig (
    input  logic [31:0]                    crc,
    input  logic                           over,
    input  logic [crcbs_pkg::SIG_W-1:0]    filter_word,
    output crcbs_pkg::out_beat_t           result
);

    logic [31:0]                      part  [crcbs_pkg::NUM_CHUNKS];
    logic [crcbs_pkg::CHUNK_BITS-1:0] idx   [crcbs_pkg::NUM_CHUNKS];
    logic [crcbs_pkg::NUM_CHUNKS-1:0] hit;
    logic [crcbs_pkg::NUM_CHUNKS-1:0] fresh;
    logic [crcbs_pkg::SIG_W-1:0]      sig;
    logic [crcbs_pkg::WEIGHT_W-1:0]   cnt;

    // chunk k: shifted crc nonzero sets bit of its low six bits
    always_comb
    begin
        for (int k = 0; k < crcbs_pkg::NUM_CHUNKS; k++)
        begin
            part[k] = crc >> (k*crcbs_pkg::CHUNK_BITS);
            idx[k]  = part[k][crcbs_pkg::CHUNK_BITS-1:0];
            hit[k]  = part[k] != 32'd0;
        end
    end

    // a chunk adds weight only when no earlier chunk set the same bit
    always_comb
    begin
        for (int k = 0; k < crcbs_pkg::NUM_CHUNKS; k++)
        begin
            fresh[k] = hit[k];
            for (int j = 0; j < k; j++)
            begin
                if (hit[j] && (idx[j] == idx[k]))
                begin
                    fresh[k] = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        sig = '0;
        cnt = '0;
        for (int k = 0; k < crcbs_pkg::NUM_CHUNKS; k++)
        begin
            if (hit[k])
            begin
                sig[idx[k]] = 1'b1;
            end
            cnt = cnt + crcbs_pkg::WEIGHT_W'(fresh[k]);
        end
    end

    always_comb
    begin
        result.signature = over ? '0 : sig;
        result.weight    = over ? '0 : cnt;
        result.contained = over ? 1'b1 : ((filter_word & sig) == sig);
        result.too_long  = over;
    end

endmodule

/* sv/crc_bloom_signature.sv */
// ============================================================================
// crc_bloom_signature : crc-32 bloom signature of a byte string
// byte-wide reflected crc-32, six-hash 64-bit signature on the last byte
// ============================================================================
// throughput: one byte beat per cycle, set by the byte-wide crc update, unless the
//   finished-crc slot is full and stalled; the edge that takes a last byte loads the
//   finished-crc register, which moves to the result register once that one is free
// reset: rst_n clears crc to all ones, the byte count, the length flag,
//   the filter word and every valid flag; no clearing pass is needed
module crc_bloom_signature (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  crcbs_pkg::in_beat_t         in_beat,
    output logic                        out_valid,
    input  logic                        out_ready,
    output crcbs_pkg::out_beat_t        out_beat,
    input  logic                        cfg_we,
    input  logic [crcbs_pkg::SIG_W-1:0] cfg_wdata
);

    // running string state
    logic [31:0]                    crc_reg,   crc_next;
    logic [crcbs_pkg::COUNT_W-1:0]  count_reg, count_next;
    logic                           over_reg,  over_next;
    logic [crcbs_pkg::SIG_W-1:0]    filter_reg;

    // finished crc waiting for the signature stage
    logic                           fin_valid_reg, fin_valid_next;
    logic [31:0]                    fin_crc_reg;
    logic                           fin_over_reg;

    // result register
    logic                           out_valid_reg, out_valid_next;
    crcbs_pkg::out_beat_t           out_reg;
    crcbs_pkg::out_beat_t           sig_result;

    logic                           in_take;
    logic                           out_free;
    logic                           fin_move;
    logic [31:0]                    crc_upd;
    logic [crcbs_pkg::COUNT_W-1:0]  count_upd;
    logic                           over_upd;

    // result register can load when empty or being emptied this cycle
    assign out_free = !out_valid_reg || out_ready;
    assign fin_move = fin_valid_reg && out_free;
    // a byte may enter whenever the finished-crc slot is free or moving on
    assign in_ready = !fin_valid_reg || out_free;
    assign in_take  = in_valid && in_ready;

    assign out_valid = out_valid_reg;
    assign out_beat  = out_reg;

    // byte-wide crc step and saturating length count
    always_comb
    begin
        crc_upd   = crcbs_pkg::crc_byte(crc_reg, in_beat.data_byte);
        count_upd = (count_reg == crcbs_pkg::COUNT_MAX) ? count_reg
                                                        : count_reg + 1'b1;
        over_upd  = over_reg || (count_upd > crcbs_pkg::LEN_LIMIT);
    end

    always_comb
    begin
        crc_next       = crc_reg;
        count_next     = count_reg;
        over_next      = over_reg;
        fin_valid_next = fin_valid_reg && !fin_move;
        out_valid_next = out_valid_reg && !out_ready;
        if (in_take)
        begin
            if (in_beat.last)
            begin
                // string done: hand the crc over and start afresh
                crc_next       = crcbs_pkg::CRC_INIT;
                count_next     = '0;
                over_next      = 1'b0;
                fin_valid_next = 1'b1;
            end
            else
            begin
                crc_next   = crc_upd;
                count_next = count_upd;
                over_next  = over_upd;
            end
        end
        if (fin_move)
        begin
            out_valid_next = 1'b1;
        end
    end

    crcbs_sig u_sig (
        .crc         (fin_crc_reg),
        .over        (fin_over_reg),
        .filter_word (filter_reg),
        .result      (sig_result)
    );

    // control and string state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= crcbs_pkg::CRC_INIT;
            count_reg     <= '0;
            over_reg      <= 1'b0;
            filter_reg    <= '0;
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            crc_reg       <= crc_next;
            count_reg     <= count_next;
            over_reg      <= over_next;
            fin_valid_reg <= fin_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                filter_reg <= cfg_wdata;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_take && in_beat.last)
        begin
            fin_crc_reg  <= crc_upd;
            fin_over_reg <= over_upd;
        end
        if (fin_move)
        begin
            out_reg <= sig_result;
        end
    end

    // an overlong string always gives the empty signature
    a_too_long_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_beat.too_long) |->
            (out_beat.signature == '0 && out_beat.weight == '0 && out_beat.contained))
        else $error("overlong string gave a non-empty signature");

    // at most one bit per chunk
    a_weight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_beat.weight <= crcbs_pkg::WEIGHT_W'(crcbs_pkg::NUM_CHUNKS)))
        else $error("signature weight above chunk count");

    // containment agrees with the held filter
    a_contained: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            (out_beat.contained == ((filter_reg & out_beat.signature) == out_beat.signature)))
        else $error("containment flag disagrees with filter");

    // the last byte restarts the string state
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_beat.last) |=>
            (crc_reg == crcbs_pkg::CRC_INIT && count_reg == '0 && !over_reg && fin_valid_reg))
        else $error("string state not restarted after last byte");

endmodule

/* test/crc_bloom_signature_tb.sv */
// ============================================================================
// crc_bloom_signature_tb : self-checking bench for the crc bloom signature
// byte strings go in with random gaps and stalls on both sides; a local
// crc-32 and signature predictor queues one expected result beat per string
// ============================================================================
module crc_bloom_signature_tb;

    localparam int WATCHDOG_LIMIT = 3000;  // cycles with no beat on either side
    localparam int HOLD_CYCLES    = 250;   // long receiver hold-off
    localparam int DRAIN_CYCLES   = 4;     // margin for a result to pass the finished-crc and result registers
    localparam int RANDOM_BYTES   = 500;
    localparam int PHASE_BYTES    = 200;

    // filter styles picked per random phase
    typedef enum int {FILT_ZERO, FILT_ONES, FILT_RANDOM, FILT_DENSE, FILT_SIGS} filt_kind_t;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_ready;
    crcbs_pkg::in_beat_t             in_beat;
    logic                            out_valid;
    logic                            out_ready;
    crcbs_pkg::out_beat_t            out_beat;
    logic                            cfg_we;
    logic [crcbs_pkg::SIG_W-1:0]     cfg_wdata;

    // predictor state, a mirror of the string in flight
    logic [31:0]                     run_crc;
    logic [crcbs_pkg::COUNT_W-1:0]   run_len;
    logic                            run_over;
    logic [crcbs_pkg::SIG_W-1:0]     filter_now;

    // expected result beats, oldest first
    crcbs_pkg::out_beat_t pending_sigs[$];
    crcbs_pkg::out_beat_t want;

    // idling controls shared between the driving processes
    logic tx_gaps;
    logic rx_stalls;
    logic hold_req;

    int errors;
    int bytes_sent;
    int results_seen;
    int filter_writes;
    int long_strings;
    int steered;
    int holds_done;
    int idle_cycles;

    crc_bloom_signature DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_beat   (in_beat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_beat  (out_beat),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // reflected crc-32, data bit folded in at each shift
    function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++)
        begin
            fb = c[0] ^ b[i];
            c  = c >> 1;
            if (fb)
                c = c ^ crcbs_pkg::CRC_POLY;
        end
        return c;
    endfunction

    // undo 32 zero-data shifts, used to steer the crc to a chosen value
    function automatic logic [31:0] crc_unshift32(input logic [31:0] crc);
        logic [31:0] c;
        c = crc;
        for (int i = 0; i < 32; i++)
            c = c[31] ? (((c ^ crcbs_pkg::CRC_POLY) << 1) | 32'd1) : (c << 1);
        return c;
    endfunction

    // result beat for a finished string
    function automatic crcbs_pkg::out_beat_t bloom_expect(
        input logic [31:0]               crc,
        input logic                      over,
        input logic [crcbs_pkg::SIG_W-1:0] filt
    );
        crcbs_pkg::out_beat_t        r;
        logic [31:0]                 part;
        logic [crcbs_pkg::SIG_W-1:0] sig;
        sig = '0;
        for (int k = 0; k < crcbs_pkg::NUM_CHUNKS; k++)
        begin
            part = crc >> (crcbs_pkg::CHUNK_BITS * k);
            if (part != 32'd0)
                sig[part[crcbs_pkg::CHUNK_BITS-1:0]] = 1'b1;
        end
        if (over)
            sig = '0;
        r.signature = sig;
        r.weight    = crcbs_pkg::WEIGHT_W'($countones(sig));
        r.contained = ((filt & sig) == sig);
        r.too_long  = over;
        return r;
    endfunction

    function automatic int pick_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(15, 45) : $urandom_range(1, 3);
    endfunction

    function automatic logic [crcbs_pkg::SIG_W-1:0] pick_filter();
        filt_kind_t                  kind;
        logic [crcbs_pkg::SIG_W-1:0] f;
        crcbs_pkg::out_beat_t        s;
        kind = filt_kind_t'($urandom_range(0, 4));
        f    = '0;
        case (kind)
            FILT_ZERO:   f = '0;
            FILT_ONES:   f = '1;
            FILT_RANDOM: f = {$urandom, $urandom};
            FILT_DENSE:
            begin
                // about seven bits in eight set, so containment is a near coin flip
                for (int i = 0; i < 3; i++)
                    f = f | {$urandom, $urandom};
            end
            FILT_SIGS:
            begin
                for (int i = 0; i < 6; i++)
                begin
                    s = bloom_expect($urandom, 1'b0, '0);
                    f = f | s.signature;
                end
            end
            default: f = '0;
        endcase
        return f;
    endfunction

    // ------------------------------------------------------------------
    // shared driving tasks; all start and end at a falling edge
    // ------------------------------------------------------------------

    task automatic send_byte(input logic [7:0] b, input logic l);
        int gap;
        in_beat  <= {b, l};
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // beat taken: advance the mirror
        bytes_sent++;
        run_crc = crc_fold(run_crc, b);
        if (run_len != crcbs_pkg::COUNT_MAX)
            run_len++;
        if (run_len > crcbs_pkg::LEN_LIMIT)
            run_over = 1'b1;
        if (l)
        begin
            pending_sigs.push_back(bloom_expect(run_crc, run_over, filter_now));
            if (run_over)
                long_strings++;
            run_crc  = crcbs_pkg::CRC_INIT;
            run_len  = '0;
            run_over = 1'b0;
        end
        @(negedge clk);
        gap = (tx_gaps && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        // valid only drops when a real gap follows
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic send_random_string(input int len);
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom_range(0, 255)), i == len - 1);
    endtask

    // four closing bytes that leave the crc at target, last on the fourth
    task automatic steer_to(input logic [31:0] target);
        logic [31:0] word;
        word = run_crc ^ crc_unshift32(target);
        steered++;
        for (int i = 0; i < 4; i++)
            send_byte(word[8*i +: 8], i == 3);
    endtask

    // sender stops and everything owed drains, plus the pipeline depth
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_sigs.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_filter(input logic [crcbs_pkg::SIG_W-1:0] value);
        wait_idle();
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we     <= 1'b0;
        filter_now  = value;
        filter_writes++;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // one-byte strings over the byte extremes and alternating patterns
    task automatic test_single_bytes();
        logic [7:0] pats [6];
        pats = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80};
        write_filter('0);
        foreach (pats[i])
            send_byte(pats[i], 1'b1);
    endtask

    // the usual check string, then crcs that hit zero chunks and top bits
    task automatic test_short_strings();
        for (int i = 1; i <= 9; i++)
            send_byte(8'h30 + 8'(i), i == 9);
        steer_to(32'h0000_0000);   // empty signature without the length flag
        steer_to(32'h0000_0040);   // chunk value 64 maps to bit 0
        steer_to(32'hFFFF_FFFF);   // chunks 0 to 4 at their top value, chunk 5 at 3
        write_filter('1);
        send_random_string(3);
        steer_to(32'h0000_0000);
    endtask

    // right at the limit, one past it, then a short string after the flag
    task automatic test_length_limit();
        write_filter({$urandom, $urandom});
        send_random_string(crcbs_pkg::MAX_LEN);
        send_random_string(crcbs_pkg::MAX_LEN + 1);
        send_random_string(2);
    endtask

    // a filter built from a known signature, the same with one bit flipped, then all ones
    task automatic test_filter_settings();
        logic [31:0]          target;
        crcbs_pkg::out_beat_t s;
        target = $urandom;
        s      = bloom_expect(target, 1'b0, '0);
        write_filter(s.signature);
        steer_to(target);
        send_random_string(5);
        write_filter(s.signature ^ (64'd1 << $urandom_range(0, 63)));
        steer_to(target);
        write_filter('1);
        send_random_string(4);
    endtask

    // receiver holds off while one-byte strings keep coming, so input stalls
    task automatic test_backpressure_fill();
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        hold_req  = 1'b1;
        for (int i = 0; i < 40; i++)
            send_byte(8'($urandom_range(0, 255)), 1'b1);
        wait_idle();
    endtask

    // phases of random strings, each with its own filter and idling mix
    task automatic test_random_streams();
        int done;
        int phase;
        int len;
        done = 0;
        while (done < RANDOM_BYTES)
        begin
            write_filter(pick_filter());
            tx_gaps   = $urandom_range(0, 3) != 0;
            rx_stalls = $urandom_range(0, 3) != 0;
            phase = 0;
            while (phase < PHASE_BYTES)
            begin
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 80) : $urandom_range(1, 12);
                if (len >= 4 && $urandom_range(0, 5) == 0)
                begin
                    // end on a chosen crc, often one with empty upper chunks
                    for (int i = 0; i < len - 4; i++)
                        send_byte(8'($urandom_range(0, 255)), 1'b0);
                    steer_to($urandom_range(0, 1) ? $urandom : ($urandom >> $urandom_range(8, 31)));
                end
                else
                    send_random_string(len);
                phase += len;
            end
            done += phase;
        end
    endtask

    // ------------------------------------------------------------------
    // receiver: random stalls, plus the long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        out_ready  = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
                holds_done++;
            end
            else if (stall_left == 0 && rx_stalls && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // result checker: each taken result beat against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_sigs.size() == 0)
            begin
                $display("%0t: unexpected result beat %h", $time, out_beat);
                errors++;
            end
            else
            begin
                want = pending_sigs.pop_front();
                if (out_beat.signature !== want.signature)
                begin
                    $display("%0t: signature expected %h actual %h",
                             $time, want.signature, out_beat.signature);
                    errors++;
                end
                if (out_beat.weight !== want.weight)
                begin
                    $display("%0t: weight expected %0d actual %0d",
                             $time, want.weight, out_beat.weight);
                    errors++;
                end
                if (out_beat.contained !== want.contained)
                begin
                    $display("%0t: contained expected %b actual %b",
                             $time, want.contained, out_beat.contained);
                    errors++;
                end
                if (out_beat.too_long !== want.too_long)
                begin
                    $display("%0t: too_long expected %b actual %b",
                             $time, want.too_long, out_beat.too_long);
                    errors++;
                end
            end
        end
    end

    // watchdog: too long without a beat on either channel means a hang
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no beat for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, pending_sigs.size());
            $display("crc_bloom_signature_tb: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_beat       = '0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        tx_gaps       = 1'b1;
        rx_stalls     = 1'b1;
        hold_req      = 1'b0;
        run_crc       = crcbs_pkg::CRC_INIT;
        run_len       = '0;
        run_over      = 1'b0;
        filter_now    = '0;
        errors        = 0;
        bytes_sent    = 0;
        results_seen  = 0;
        filter_writes = 0;
        long_strings  = 0;
        steered       = 0;
        holds_done    = 0;
        idle_cycles   = 0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_single_bytes();
        test_short_strings();
        test_length_limit();
        test_filter_settings();
        test_backpressure_fill();
        test_random_streams();

        // drain, then keep waiting to catch any stray result beat
        wait_idle();
        repeat (2 * DRAIN_CYCLES) @(negedge clk);

        $display("run covered %0d byte beats, %0d result beats, %0d filter settings",
                 bytes_sent, results_seen, filter_writes);
        $display("incl. %0d over-length strings, %0d steered crc endings, %0d long hold-offs",
                 long_strings, steered, holds_done);
        if (errors == 0 && pending_sigs.size() == 0)
            $display("crc_bloom_signature_tb: PASS");
        else
            $display("crc_bloom_signature_tb: FAIL");
        $finish;
    end

endmodule
